@@ design/vmalu_pkg.sv @@
package vmalu_pkg;

   localparam int NumRegsDefault  = 32;
   localparam int WordBitsDefault = 64;
   localparam int CmdBits         = 6;
   localparam int RegIdxBits      = 5;
   localparam int ImmBits         = 64;
   localparam int SelBits         = 32;
   localparam int ExitBits        = 8;
   localparam int ReqDataBits     = 120;
   localparam int RspDataBits     = 152;

   typedef enum logic [CmdBits-1:0] {
      OP_HCF  = 6'd0,  OP_MOV  = 6'd1,  OP_MOVI = 6'd2,  OP_ADD  = 6'd3,
      OP_ADDI = 6'd4,  OP_SUB  = 6'd5,  OP_SUBI = 6'd6,  OP_NEG  = 6'd7,
      OP_MUL  = 6'd8,  OP_MUC  = 6'd9,  OP_IMUL = 6'd10, OP_DIV  = 6'd11,
      OP_DVR  = 6'd12, OP_IDIV = 6'd13, OP_IDVR = 6'd14, OP_OR   = 6'd15,
      OP_ORI  = 6'd16, OP_XOR  = 6'd17, OP_XORI = 6'd18, OP_AND  = 6'd19,
      OP_ANDI = 6'd20, OP_INV  = 6'd21, OP_SZR  = 6'd22, OP_SZRI = 6'd23,
      OP_SAR  = 6'd24, OP_SARI = 6'd25, OP_SHL  = 6'd26, OP_SHLI = 6'd27,
      OP_ROL  = 6'd28, OP_ROLI = 6'd29, OP_BIT  = 6'd30, OP_ANY  = 6'd31,
      OP_ALL  = 6'd32, OP_EQ   = 6'd33, OP_EQI  = 6'd34, OP_NE   = 6'd35,
      OP_NEI  = 6'd36, OP_BL   = 6'd37, OP_BLI  = 6'd38, OP_BLE  = 6'd39,
      OP_BLEI = 6'd40, OP_LT   = 6'd41, OP_LTI  = 6'd42, OP_LTE  = 6'd43,
      OP_LTEI = 6'd44, OP_EXIT = 6'd45
   } opcode_type;

endpackage

@@ design/vm_register_alu_execute.sv @@
// Channel | Direction | Fields (tdata lowest bit first)
// req_    | in        | command, dst_reg, src_reg, third_reg, immediate, reg_select
// rsp_    | out       | write_valid, written_reg, written_value, second_valid,
//         |           | second_reg, second_value, divide_error, halted, exit_code
//
// A result passes through the read, execute and done states for simple operations;
// shifts, rotates and BIT add the shift state, ANY and ALL the register scan and the
// shift state, multiply the shift-add state, and divide the magnitude, restoring
// and fix-up states. A divide by zero and any item after a halt go from execute to done.
// Reset clears the register file, the halt flag and the exit code at once.
// A result waits in the output register while rsp_tready is low; the next transaction is
// accepted no earlier than the cycle after the result has been delivered.
module vm_register_alu_execute #(
   parameter int NUM_REGS  = vmalu_pkg::NumRegsDefault,
   parameter int WORD_BITS = vmalu_pkg::WordBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // command, dst_reg, src_reg, third_reg, immediate, reg_select
   input  logic [vmalu_pkg::ReqDataBits-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // write_valid, written_reg, written_value, second_valid, second_reg,
   // second_value, divide_error, halted, exit_code
   output logic [vmalu_pkg::RspDataBits-1:0]  rsp_tdata
);

   localparam int RIB = $clog2(NUM_REGS);
   localparam int SB  = $clog2(WORD_BITS);
   localparam int CB  = $clog2(WORD_BITS + 1);
   localparam int RCB = $clog2(NUM_REGS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIVPRE, ST_DIV, ST_DIVFIX, ST_DIVFIX2,
      ST_SCAN, ST_SHIFT, ST_DONE
   } state_type;

   word_type regs_ff [NUM_REGS];
   logic halt_ff, halt_in;
   logic [7:0] exit_ff, exit_in;
   state_type state_ff;

   vmalu_pkg::opcode_type cmd_ff;
   logic [RIB-1:0] d_ff, s_ff, t_ff;
   word_type imm_ff;
   logic [NUM_REGS-1:0] sel_ff;
   word_type a_ff, b_ff, c_ff;
   word_type acc_ff, aux_ff, op_ff;
   logic [CB-1:0] cnt_ff;
   logic [RCB-1:0] rcnt_ff;
   logic flag_ff;
   logic [SB-1:0] sh_ff;

   logic wv_ff, sv_ff, de_ff;
   logic [RIB-1:0] wr_ff, sr_ff;
   word_type wval_ff, sval_ff;
   logic rvalid_ff;

   // Shared adder.
   word_type add_x, add_y;
   logic add_sub;
   logic [WORD_BITS:0] add_sum;
   assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + {{WORD_BITS{1'b0}}, add_sub};

   logic [RIB-1:0] rd_d, rd_s, rd_t;
   assign rd_d = RIB'(req_tdata[10:6]  % NUM_REGS);
   assign rd_s = RIB'(req_tdata[15:11] % NUM_REGS);
   assign rd_t = RIB'(req_tdata[20:16] % NUM_REGS);

   logic na, nb;
   assign na = a_ff[WORD_BITS-1];
   assign nb = c_ff[WORD_BITS-1];

   always_comb begin
      add_x = acc_ff;
      add_y = op_ff;
      add_sub = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            add_x = a_ff;
            case (cmd_ff)
               vmalu_pkg::OP_ADD:  begin add_y = b_ff; end
               vmalu_pkg::OP_ADDI: begin add_y = imm_ff; end
               vmalu_pkg::OP_SUB:  begin add_y = b_ff; add_sub = 1'b1; end
               vmalu_pkg::OP_SUBI: begin add_y = imm_ff; add_sub = 1'b1; end
               vmalu_pkg::OP_NEG:  begin add_x = '0; add_y = b_ff; add_sub = 1'b1; end
               vmalu_pkg::OP_EQ, vmalu_pkg::OP_NE,
               vmalu_pkg::OP_BL, vmalu_pkg::OP_BLE, vmalu_pkg::OP_LT,
               vmalu_pkg::OP_LTE: begin
                  add_x = b_ff; add_y = c_ff; add_sub = 1'b1;
               end
               vmalu_pkg::OP_EQI, vmalu_pkg::OP_NEI,
               vmalu_pkg::OP_BLI, vmalu_pkg::OP_BLEI, vmalu_pkg::OP_LTI,
               vmalu_pkg::OP_LTEI: begin
                  add_x = b_ff; add_y = imm_ff; add_sub = 1'b1;
               end
               default: begin add_y = b_ff; end
            endcase
         end
         ST_MUL: begin
            add_x = acc_ff;
            add_y = aux_ff[0] ? op_ff : '0;
         end
         ST_DIVPRE: begin
            add_x = '0; add_sub = 1'b1;
            add_y = flag_ff ? c_ff : a_ff;
         end
         ST_DIV: begin
            add_x = {acc_ff[WORD_BITS-2:0], aux_ff[WORD_BITS-1]};
            add_y = op_ff; add_sub = 1'b1;
         end
         ST_DIVFIX: begin
            add_x = '0; add_y = aux_ff; add_sub = 1'b1;
         end
         ST_DIVFIX2: begin
            add_x = '0; add_y = acc_ff; add_sub = 1'b1;
         end
         default: begin
            add_x = acc_ff; add_y = op_ff;
         end
      endcase
   end

   logic eqf, ltu, lts;
   assign eqf = (add_sum[WORD_BITS-1:0] == '0);
   assign ltu = ~add_sum[WORD_BITS];
   assign lts = (add_x[WORD_BITS-1] ^ add_y[WORD_BITS-1]) ? add_x[WORD_BITS-1]
                                                          : add_sum[WORD_BITS-1];

   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0]       = wv_ff;
      rsp_tdata[5:1]     = wv_ff ? 5'(wr_ff) : 5'd0;
      rsp_tdata[69:6]    = 64'(wval_ff);
      rsp_tdata[70]      = sv_ff;
      rsp_tdata[75:71]   = sv_ff ? 5'(sr_ff) : 5'd0;
      rsp_tdata[139:76]  = 64'(sval_ff);
      rsp_tdata[140]     = de_ff;
      rsp_tdata[141]     = halt_ff;
      rsp_tdata[149:142] = exit_ff;
   end

   always_comb begin
      halt_in = halt_ff;
      exit_in = exit_ff;
      if (state_ff == ST_EXEC && !halt_ff) begin
         if (cmd_ff == vmalu_pkg::OP_HCF) begin
            halt_in = 1'b1; exit_in = 8'hff;
         end else if (cmd_ff == vmalu_pkg::OP_EXIT) begin
            halt_in = 1'b1; exit_in = 8'(b_ff);
         end
      end
   end

   word_type zext1;
   word_type b_shl, b_shr, b_sar;
   logic [SB-1:0] sh_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         halt_ff   <= 1'b0;
         exit_ff   <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         halt_ff <= halt_in;
         exit_ff <= exit_in;
         if (rvalid_ff && rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cmd_ff <= vmalu_pkg::opcode_type'(req_tdata[5:0]);
                  d_ff   <= rd_d;
                  s_ff   <= rd_s;
                  t_ff   <= rd_t;
                  imm_ff <= WORD_BITS'(req_tdata[84:21]);
                  sel_ff <= NUM_REGS'(req_tdata[116:85]);
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               a_ff <= regs_ff[d_ff];
               b_ff <= regs_ff[s_ff];
               c_ff <= regs_ff[t_ff];
               wv_ff <= 1'b0; sv_ff <= 1'b0; de_ff <= 1'b0;
               wr_ff <= d_ff; sr_ff <= s_ff;
               wval_ff <= '0; sval_ff <= '0;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_DONE;
               if (!halt_ff) begin
                  case (cmd_ff)
                     vmalu_pkg::OP_MOV:  begin wv_ff <= 1'b1; wval_ff <= b_ff; end
                     vmalu_pkg::OP_MOVI: begin wv_ff <= 1'b1; wval_ff <= imm_ff; end
                     vmalu_pkg::OP_ADD, vmalu_pkg::OP_ADDI, vmalu_pkg::OP_SUB,
                     vmalu_pkg::OP_SUBI, vmalu_pkg::OP_NEG: begin
                        wv_ff <= 1'b1; wval_ff <= add_sum[WORD_BITS-1:0];
                     end
                     vmalu_pkg::OP_MUL, vmalu_pkg::OP_IMUL, vmalu_pkg::OP_MUC: begin
                        acc_ff <= '0;
                        op_ff  <= (cmd_ff == vmalu_pkg::OP_MUC) ? b_ff : a_ff;
                        aux_ff <= (cmd_ff == vmalu_pkg::OP_MUC) ? c_ff : b_ff;
                        cnt_ff <= '0;
                        state_ff <= ST_MUL;
                     end
                     vmalu_pkg::OP_DIV, vmalu_pkg::OP_DVR, vmalu_pkg::OP_IDIV,
                     vmalu_pkg::OP_IDVR: begin
                        if (cmd_ff == vmalu_pkg::OP_DIV || cmd_ff == vmalu_pkg::OP_IDIV) begin
                           c_ff <= b_ff;
                        end
                        if (((cmd_ff == vmalu_pkg::OP_DIV || cmd_ff == vmalu_pkg::OP_IDIV)
                             ? b_ff : c_ff) == '0) begin
                           de_ff <= 1'b1;
                        end else begin
                           flag_ff <= 1'b0;
                           state_ff <= ST_DIVPRE;
                        end
                     end
                     vmalu_pkg::OP_OR:   begin wv_ff <= 1'b1; wval_ff <= a_ff | b_ff; end
                     vmalu_pkg::OP_ORI:  begin wv_ff <= 1'b1; wval_ff <= a_ff | imm_ff; end
                     vmalu_pkg::OP_XOR:  begin wv_ff <= 1'b1; wval_ff <= a_ff ^ b_ff; end
                     vmalu_pkg::OP_XORI: begin wv_ff <= 1'b1; wval_ff <= a_ff ^ imm_ff; end
                     vmalu_pkg::OP_AND:  begin wv_ff <= 1'b1; wval_ff <= a_ff & b_ff; end
                     vmalu_pkg::OP_ANDI: begin wv_ff <= 1'b1; wval_ff <= a_ff & imm_ff; end
                     vmalu_pkg::OP_INV:  begin wv_ff <= 1'b1; wval_ff <= ~b_ff; end
                     vmalu_pkg::OP_SZR, vmalu_pkg::OP_SAR, vmalu_pkg::OP_SHL,
                     vmalu_pkg::OP_ROL: begin
                        sh_ff <= c_ff[SB-1:0]; state_ff <= ST_SHIFT;
                     end
                     vmalu_pkg::OP_SZRI, vmalu_pkg::OP_SARI, vmalu_pkg::OP_SHLI,
                     vmalu_pkg::OP_ROLI, vmalu_pkg::OP_BIT: begin
                        sh_ff <= imm_ff[SB-1:0]; state_ff <= ST_SHIFT;
                     end
                     vmalu_pkg::OP_ANY, vmalu_pkg::OP_ALL: begin
                        flag_ff <= (cmd_ff == vmalu_pkg::OP_ALL);
                        rcnt_ff <= '0;
                        state_ff <= ST_SCAN;
                     end
                     vmalu_pkg::OP_EQ, vmalu_pkg::OP_EQI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(eqf);
                     end
                     vmalu_pkg::OP_NE, vmalu_pkg::OP_NEI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(!eqf);
                     end
                     vmalu_pkg::OP_BL, vmalu_pkg::OP_BLI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(ltu);
                     end
                     vmalu_pkg::OP_BLE, vmalu_pkg::OP_BLEI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(ltu | eqf);
                     end
                     vmalu_pkg::OP_LT, vmalu_pkg::OP_LTI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(lts);
                     end
                     vmalu_pkg::OP_LTE, vmalu_pkg::OP_LTEI: begin
                        wv_ff <= 1'b1; wval_ff <= WORD_BITS'(lts | eqf);
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_MUL: begin
               // Product high half lives in acc_ff, low half shifts into aux_ff.
               acc_ff <= add_sum[WORD_BITS:1];
               aux_ff <= {add_sum[0], aux_ff[WORD_BITS-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CB'(WORD_BITS - 1)) begin
                  if (cmd_ff == vmalu_pkg::OP_MUC) begin
                     wv_ff <= 1'b1; wval_ff <= add_sum[WORD_BITS:1];
                     sv_ff <= 1'b1; sval_ff <= {add_sum[0], aux_ff[WORD_BITS-1:1]};
                  end else begin
                     wv_ff <= 1'b1; wval_ff <= {add_sum[0], aux_ff[WORD_BITS-1:1]};
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DIVPRE: begin
               // Two passes: magnitude of dividend, then of divisor.
               if (!flag_ff) begin
                  aux_ff <= (cmd_ff == vmalu_pkg::OP_IDIV || cmd_ff == vmalu_pkg::OP_IDVR)
                            && na ? add_sum[WORD_BITS-1:0] : a_ff;
                  flag_ff <= 1'b1;
               end else begin
                  op_ff <= (cmd_ff == vmalu_pkg::OP_IDIV || cmd_ff == vmalu_pkg::OP_IDVR)
                           && nb ? add_sum[WORD_BITS-1:0] : c_ff;
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // Restoring step: remainder in acc_ff, quotient shifts into aux_ff.
               if (!add_sum[WORD_BITS] && !acc_ff[WORD_BITS-1]) begin
                  acc_ff <= {acc_ff[WORD_BITS-2:0], aux_ff[WORD_BITS-1]};
                  aux_ff <= {aux_ff[WORD_BITS-2:0], 1'b0};
               end else begin
                  acc_ff <= add_sum[WORD_BITS-1:0];
                  aux_ff <= {aux_ff[WORD_BITS-2:0], 1'b1};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CB'(WORD_BITS - 1)) begin
                  state_ff <= ST_DIVFIX;
               end
            end
            ST_DIVFIX: begin
               if ((cmd_ff == vmalu_pkg::OP_IDIV || cmd_ff == vmalu_pkg::OP_IDVR)
                   && (na != nb)) begin
                  aux_ff <= add_sum[WORD_BITS-1:0];
               end
               state_ff <= ST_DIVFIX2;
            end
            ST_DIVFIX2: begin
               state_ff <= ST_DONE;
               wv_ff <= 1'b1;
               if (cmd_ff == vmalu_pkg::OP_DIV || cmd_ff == vmalu_pkg::OP_DVR) begin
                  wval_ff <= aux_ff;
                  if (cmd_ff == vmalu_pkg::OP_DVR) begin
                     sv_ff <= 1'b1; sval_ff <= acc_ff;
                  end
               end else if (cmd_ff == vmalu_pkg::OP_IDIV) begin
                  wval_ff <= aux_ff;
               end else begin
                  // Floored: nonzero magnitude remainder with differing signs adjusts.
                  sv_ff <= 1'b1;
                  if (acc_ff != '0 && (na != nb)) begin
                     wval_ff <= aux_ff - 1'b1;
                     sval_ff <= (na ? add_sum[WORD_BITS-1:0] : acc_ff) + c_ff;
                  end else begin
                     wval_ff <= aux_ff;
                     sval_ff <= na ? add_sum[WORD_BITS-1:0] : acc_ff;
                  end
               end
            end
            ST_SCAN: begin
               if (sel_ff[rcnt_ff[RIB-1:0]]) begin
                  if (cmd_ff == vmalu_pkg::OP_ANY && regs_ff[rcnt_ff[RIB-1:0]] != '0) begin
                     flag_ff <= 1'b1;
                  end
                  if (cmd_ff == vmalu_pkg::OP_ALL && regs_ff[rcnt_ff[RIB-1:0]] == '0) begin
                     flag_ff <= 1'b0;
                  end
               end
               rcnt_ff <= rcnt_ff + 1'b1;
               if (rcnt_ff == RCB'(NUM_REGS - 1)) begin
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               wv_ff <= 1'b1;
               state_ff <= ST_DONE;
               case (cmd_ff)
                  vmalu_pkg::OP_SZR, vmalu_pkg::OP_SZRI: begin wval_ff <= b_shr; end
                  vmalu_pkg::OP_SAR, vmalu_pkg::OP_SARI: begin wval_ff <= b_sar; end
                  vmalu_pkg::OP_SHL, vmalu_pkg::OP_SHLI: begin wval_ff <= b_shl; end
                  vmalu_pkg::OP_ROL, vmalu_pkg::OP_ROLI: begin
                     wval_ff <= b_shl | (sh_cnt == '0 ? '0 : (b_ff >> (WORD_BITS - sh_cnt)));
                  end
                  vmalu_pkg::OP_BIT: begin wval_ff <= zext1; end
                  default: begin wval_ff <= WORD_BITS'(flag_ff); end
               endcase
            end
            ST_DONE: begin
               // The remainder wins over the quotient, the high half over the low half.
               if (wv_ff && sv_ff && cmd_ff != vmalu_pkg::OP_MUC) begin
                  regs_ff[sr_ff] <= sval_ff;
                  if (sr_ff != wr_ff) begin
                     regs_ff[wr_ff] <= wval_ff;
                  end
               end else begin
                  if (sv_ff && !(wv_ff && sr_ff == wr_ff)) begin
                     regs_ff[sr_ff] <= sval_ff;
                  end
                  if (wv_ff) begin
                     regs_ff[wr_ff] <= wval_ff;
                  end
               end
               rvalid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign sh_cnt = sh_ff;
   assign b_shl  = b_ff << sh_cnt;
   assign b_shr  = b_ff >> sh_cnt;
   assign b_sar  = word_type'($signed(b_ff) >>> sh_cnt);
   assign zext1  = WORD_BITS'(b_shr[0]);

endmodule
